>>> hw/rtl/rcd_pkg.sv
// Shared constants and types for the row cache directory.
package rcd_pkg;

   localparam int NUM_SLOTS  = 20;
   localparam int MAX_ROWS   = 4096;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int ROW_ADDR_W = $clog2(MAX_ROWS);

   // Port field widths
   localparam int ROW_W      = 16;
   localparam int HEIGHT_W   = 13;
   localparam int OUT_SLOT_W = 5;
   localparam int EV_ROW_W   = 12;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);

   typedef struct packed {
      logic              mapped;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   localparam int MAP_W = $bits(map_entry_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT
   } state_type;

endpackage

>>> hw/rtl/rcd_if.sv
// Channel interfaces for request, response and height register write.
interface rcd_req_if;
   logic                         valid;
   logic                         ready;
   logic [rcd_pkg::ROW_W-1:0]    row;

   modport source (output valid, output row, input ready);
   modport sink   (input valid, input row, output ready);
endinterface

interface rcd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rcd_pkg::OUT_SLOT_W-1:0]  slot;
   logic                            hit;
   logic                            evicted_valid;
   logic [rcd_pkg::EV_ROW_W-1:0]    evicted_row;
   logic                            out_of_range;

   modport source (output valid, output slot, output hit, output evicted_valid,
                   output evicted_row, output out_of_range, input ready);
   modport sink   (input valid, input slot, input hit, input evicted_valid,
                   input evicted_row, input out_of_range, output ready);
endinterface

interface rcd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rcd_pkg::HEIGHT_W-1:0]    image_height;

   modport source (output valid, output image_height, input ready);
   modport sink   (input valid, input image_height, output ready);
endinterface

>>> hw/rtl/rcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/row_cache_directory_unit.sv
// Row cache directory: row-to-slot map in RAM, per-slot rows, round-robin victim.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------
//  req     | in  | valid/ready   | row[15:0]
//  rsp     | out | valid/ready   | slot[4:0] hit evicted_valid evicted_row[11:0]
//          |     |               | out_of_range
//  csr     | in  | valid/ready   | image_height[12:0] (ready always high)
//
// A hit or out-of-range request passes through the map RAM read and the lookup
// step, which decides and writes the new mapping on a miss; a miss that evicts
// adds an evict step that unmaps the evicted row through the same write port.
// After reset the map RAM is cleared one entry a cycle, all MAX_ROWS (4096)
// entries with req.ready low; csr writes are taken throughout.
// A stalled rsp holds the result in its output register; a new request is
// still taken, and waits in the lookup step until the register frees.
module row_cache_directory_unit (
   input  logic              clock,
   input  logic              reset,
   rcd_req_if.sink           req,
   rcd_rsp_if.source         rsp,
   rcd_csr_if.sink           csr
);

   localparam logic [rcd_pkg::SLOT_W-1:0] LAST_SLOT =
      rcd_pkg::SLOT_W'(rcd_pkg::NUM_SLOTS - 1);
   localparam logic [rcd_pkg::ROW_ADDR_W-1:0] LAST_ROW =
      rcd_pkg::ROW_ADDR_W'(rcd_pkg::MAX_ROWS - 1);

   rcd_pkg::state_type state_ff, state_in;

   logic [rcd_pkg::ROW_ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [rcd_pkg::HEIGHT_W-1:0]   height_ff, height_in;
   logic [rcd_pkg::ROW_ADDR_W-1:0] row_ff;
   logic                           oor_ff;
   logic [rcd_pkg::SLOT_W-1:0]     victim_ff, victim_in;
   logic [rcd_pkg::ROW_ADDR_W-1:0] slot_row_ff [rcd_pkg::NUM_SLOTS];
   logic [rcd_pkg::NUM_SLOTS-1:0]  slot_full_ff, slot_full_in;
   logic [rcd_pkg::ROW_ADDR_W-1:0] evict_row_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rcd_pkg::OUT_SLOT_W-1:0] rsp_slot_ff;
   logic                           rsp_hit_ff;
   logic                           rsp_ev_valid_ff;
   logic [rcd_pkg::EV_ROW_W-1:0]   rsp_ev_row_ff;
   logic                           rsp_oor_ff;

   // RAM port
   logic                           ram_wr_en;
   logic [rcd_pkg::ROW_ADDR_W-1:0] ram_wr_addr;
   rcd_pkg::map_entry_type         ram_wr_data;
   logic                           ram_rd_en;
   logic [rcd_pkg::MAP_W-1:0]      ram_rd_raw;
   rcd_pkg::map_entry_type         ram_rd_data;

   // Decode
   logic                           req_xfer;
   logic                           req_oor;
   logic                           out_free;
   logic                           lookup_go;
   logic                           is_miss;
   logic                           victim_full;
   logic                           rsp_load;

   rcd_ram #(
      .WIDTH (rcd_pkg::MAP_W),
      .DEPTH (rcd_pkg::MAX_ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req.row[rcd_pkg::ROW_ADDR_W-1:0]),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = rcd_pkg::map_entry_type'(ram_rd_raw);

   assign req_xfer = req.valid && req.ready;
   assign req_oor  = ({1'b0, req.row} >= {4'b0, height_ff})
                  || ({1'b0, req.row} >= (rcd_pkg::ROW_W + 1)'(rcd_pkg::MAX_ROWS));
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign lookup_go   = (state_ff == rcd_pkg::ST_LOOKUP) && out_free;
   assign is_miss     = !oor_ff && !ram_rd_data.mapped;
   assign victim_full = slot_full_ff[victim_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcd_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ROW) begin
               state_in = rcd_pkg::ST_IDLE;
            end
         end
         rcd_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = rcd_pkg::ST_LOOKUP;
            end
         end
         rcd_pkg::ST_LOOKUP: begin
            if (out_free) begin
               state_in = (is_miss && victim_full) ? rcd_pkg::ST_EVICT : rcd_pkg::ST_IDLE;
            end
         end
         rcd_pkg::ST_EVICT: begin
            state_in = rcd_pkg::ST_IDLE;
         end
         default: begin
            state_in = rcd_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs and datapath controls
   always_comb begin
      req.ready    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;
      clr_addr_in  = clr_addr_ff;
      victim_in    = victim_ff;
      slot_full_in = slot_full_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         rcd_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         rcd_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            ram_rd_en = req.valid;
         end
         rcd_pkg::ST_LOOKUP: begin
            rsp_load = out_free;
            if (lookup_go && is_miss) begin
               ram_wr_en                = 1'b1;
               ram_wr_addr              = row_ff;
               ram_wr_data.mapped       = 1'b1;
               ram_wr_data.slot         = victim_ff;
               slot_full_in[victim_ff]  = 1'b1;
               victim_in = (victim_ff == LAST_SLOT) ? '0 : victim_ff + 1'b1;
            end
         end
         rcd_pkg::ST_EVICT: begin
            // unmap the row that lost its slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = evict_row_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   assign height_in    = csr.valid ? csr.image_height : height_ff;
   assign csr.ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcd_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         height_ff    <= rcd_pkg::HEIGHT_RESET;
         victim_ff    <= '0;
         slot_full_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         height_ff    <= height_in;
         victim_ff    <= victim_in;
         slot_full_ff <= slot_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         row_ff <= req.row[rcd_pkg::ROW_ADDR_W-1:0];
         oor_ff <= req_oor;
      end
      if (lookup_go && is_miss) begin
         slot_row_ff[victim_ff] <= row_ff;
         evict_row_ff           <= slot_row_ff[victim_ff];
      end
      if (rsp_load) begin
         rsp_oor_ff      <= oor_ff;
         rsp_hit_ff      <= !oor_ff && ram_rd_data.mapped;
         rsp_ev_valid_ff <= is_miss && victim_full;
         if (oor_ff) begin
            rsp_slot_ff <= '0;
         end else if (ram_rd_data.mapped) begin
            rsp_slot_ff <= rcd_pkg::OUT_SLOT_W'(ram_rd_data.slot);
         end else begin
            rsp_slot_ff <= rcd_pkg::OUT_SLOT_W'(victim_ff);
         end
         if (is_miss && victim_full) begin
            rsp_ev_row_ff <= rcd_pkg::EV_ROW_W'(slot_row_ff[victim_ff]);
         end else begin
            rsp_ev_row_ff <= '0;
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.slot          = rsp_slot_ff;
   assign rsp.hit           = rsp_hit_ff;
   assign rsp.evicted_valid = rsp_ev_valid_ff;
   assign rsp.evicted_row   = rsp_ev_row_ff;
   assign rsp.out_of_range  = rsp_oor_ff;

endmodule

>>> hw/rtl/rcd_checker.sv
// Port-level checks for the row cache directory, bound to the top level.
module rcd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rcd_pkg::OUT_SLOT_W-1:0] rsp_slot,
   input logic                           rsp_hit,
   input logic                           rsp_evicted_valid,
   input logic [rcd_pkg::EV_ROW_W-1:0]   rsp_evicted_row,
   input logic                           rsp_out_of_range
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] owed_ff, owed_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign owed_in  = owed_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_in;
      end
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit)
         && $stable(rsp_evicted_valid) && $stable(rsp_evicted_row)
         && $stable(rsp_out_of_range))
      else $error("rsp changed while stalled");

   // every response answers an accepted request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != 2'd0)
      else $error("response without request");

   // at most one finished result waits when a new request is taken
   a_one_ahead: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> owed_ff <= 2'd1)
      else $error("request taken with too many outstanding");

   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_slot == '0 && !rsp_hit
         && !rsp_evicted_valid && rsp_evicted_row == '0)
      else $error("out of range response not clean");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid && rsp_evicted_row == '0
         && !rsp_out_of_range)
      else $error("hit response reports eviction");

endmodule

bind row_cache_directory_unit rcd_checker u_rcd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_slot          (rsp.slot),
   .rsp_hit           (rsp.hit),
   .rsp_evicted_valid (rsp.evicted_valid),
   .rsp_evicted_row   (rsp.evicted_row),
   .rsp_out_of_range  (rsp.out_of_range)
);

>>> dv/tb.sv
// Testbench for the row cache directory: directed table, random phases, per-field check.
`timescale 1ns / 100ps

module tb;

   localparam int STALL_LIMIT = 3 * rcd_pkg::MAX_ROWS;

   typedef struct packed {
      logic [rcd_pkg::OUT_SLOT_W-1:0] slot;
      logic                           hit;
      logic                           evicted_valid;
      logic [rcd_pkg::EV_ROW_W-1:0]   evicted_row;
      logic                           out_of_range;
   } lookup_type;

   typedef enum logic {DIR_ROW, DIR_HEIGHT} dir_kind_type;

   typedef struct {
      dir_kind_type kind;
      logic [15:0]  value;
      bit           typed;
      lookup_type   want;
   } dir_step_type;

   logic clock;
   logic reset;

   rcd_req_if req_bus ();
   rcd_rsp_if rsp_bus ();
   rcd_csr_if csr_bus ();

   row_cache_directory_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // directory shadow
   logic [rcd_pkg::HEIGHT_W-1:0]   height_q = rcd_pkg::HEIGHT_RESET;
   bit                             row_held [rcd_pkg::MAX_ROWS];
   logic [rcd_pkg::OUT_SLOT_W-1:0] held_slot [rcd_pkg::MAX_ROWS];
   bit                             slot_full [rcd_pkg::NUM_SLOTS];
   logic [rcd_pkg::ROW_ADDR_W-1:0] slot_row [rcd_pkg::NUM_SLOTS];
   int unsigned                    victim = 0;

   lookup_type   due_lookups[$];
   dir_step_type plan[$];
   int           error_count = 0;
   bit           steady = 1'b0;
   int unsigned  ws_base = 0;
   int unsigned  ws_size = 16;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic lookup_type lookup_row(input logic [rcd_pkg::ROW_W-1:0] r);
      lookup_type  res;
      int unsigned s;
      res = '0;
      if (r >= height_q || r >= rcd_pkg::MAX_ROWS) begin
         res.out_of_range = 1'b1;
      end else if (row_held[r]) begin
         res.hit  = 1'b1;
         res.slot = held_slot[r];
      end else begin
         s = victim;
         if (slot_full[s]) begin
            res.evicted_valid = 1'b1;
            res.evicted_row   = slot_row[s];
            row_held[slot_row[s]] = 1'b0;
         end
         slot_full[s] = 1'b1;
         slot_row[s]  = rcd_pkg::ROW_ADDR_W'(r);
         row_held[r]  = 1'b1;
         held_slot[r] = rcd_pkg::OUT_SLOT_W'(s);
         res.slot     = rcd_pkg::OUT_SLOT_W'(s);
         victim       = (s + 1 == rcd_pkg::NUM_SLOTS) ? 0 : s + 1;
      end
      return res;
   endfunction

   function automatic void add_height(input int h);
      plan.push_back('{kind: DIR_HEIGHT, value: 16'(h), typed: 1'b0, want: '0});
   endfunction

   function automatic void add_row(input int r, input bit typed, input int slot,
                                   input bit hit, input bit ev, input int ev_row,
                                   input bit oor);
      lookup_type w;
      w.slot          = rcd_pkg::OUT_SLOT_W'(slot);
      w.hit           = hit;
      w.evicted_valid = ev;
      w.evicted_row   = rcd_pkg::EV_ROW_W'(ev_row);
      w.out_of_range  = oor;
      plan.push_back('{kind: DIR_ROW, value: 16'(r), typed: typed, want: w});
   endfunction

   function automatic logic [rcd_pkg::ROW_W-1:0] pick_row(input int unsigned span);
      int unsigned p;
      p = $urandom_range(0, 99);
      if (span != 0 && p < 65) begin
         return rcd_pkg::ROW_W'((ws_base + $urandom_range(0, ws_size - 1)) % span);
      end
      if (span != 0 && p < 85) return rcd_pkg::ROW_W'($urandom_range(0, span - 1));
      return rcd_pkg::ROW_W'($urandom_range(0, 16'hFFFF));
   endfunction

   task automatic send_row(input logic [rcd_pkg::ROW_W-1:0] r, input bit typed,
                           input lookup_type want);
      lookup_type predicted;
      if (!steady && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.row   <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = lookup_row(r);
      due_lookups.push_back(typed ? want : predicted);
   endtask

   // let outstanding lookups come back before touching the height register
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (due_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_height(input logic [rcd_pkg::HEIGHT_W-1:0] h);
      csr_bus.valid        <= 1'b1;
      csr_bus.image_height <= h;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      height_q = h;
      csr_bus.valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [rcd_pkg::HEIGHT_W-1:0] phase_heights [8];
      int unsigned                  span;
      int                           count;

      req_bus.valid        <= 1'b0;
      req_bus.row          <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.image_height <= rcd_pkg::HEIGHT_RESET;

      add_height(4096);
      add_row(0,     1, 0, 0, 0, 0, 0);
      add_row(0,     1, 0, 1, 0, 0, 0);
      add_row(4095,  1, 1, 0, 0, 0, 0);
      add_row(4096,  1, 0, 0, 0, 0, 1);
      add_row(65535, 1, 0, 0, 0, 0, 1);
      add_height(8191);
      add_row(4096,  1, 0, 0, 0, 0, 1);
      add_row(4095,  1, 1, 1, 0, 0, 0);
      add_height(0);
      add_row(0,     1, 0, 0, 0, 0, 1);
      add_height(1);
      add_row(0,     1, 0, 1, 0, 0, 0);
      add_row(1,     1, 0, 0, 0, 0, 1);
      add_height(100);
      add_row(4095,  1, 0, 0, 0, 0, 1);
      for (int r = 2; r < rcd_pkg::NUM_SLOTS; r++) add_row(r, 0, 0, 0, 0, 0, 0);
      // pointer wraps; slot 1 still holds a row above the lowered height
      add_row(20,    1, 0, 0, 1, 0, 0);
      add_row(21,    1, 1, 0, 1, 4095, 0);

      phase_heights = '{13'd4096, 13'd64, 13'd8191, 13'd0, 13'd1, 13'd0, 13'd0, 13'd4096};
      phase_heights[5] = rcd_pkg::HEIGHT_W'($urandom_range(2, 4095));
      phase_heights[6] = rcd_pkg::HEIGHT_W'($urandom_range(1, 8191));

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == DIR_HEIGHT) begin
            settle();
            write_height(rcd_pkg::HEIGHT_W'(plan[i].value));
         end else begin
            send_row(plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < 8; p++) begin
         settle();
         write_height(phase_heights[p]);
         steady = (p == 6);
         span   = (phase_heights[p] > rcd_pkg::MAX_ROWS) ? rcd_pkg::MAX_ROWS
                                                          : phase_heights[p];
         count  = (phase_heights[p] == 0) ? 40 : (phase_heights[p] == 1) ? 60 : 230;
         for (int i = 0; i < count; i++) begin
            if (i % 50 == 0 && span != 0) begin
               ws_base = $urandom_range(0, span - 1);
               ws_size = $urandom_range(8, 40);
            end
            send_row(pick_row(span), 1'b0, '0);
         end
      end
      steady = 1'b0;

      req_bus.valid <= 1'b0;
      while (due_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // response side: random backpressure, compare against oldest expectation
   initial begin
      lookup_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (due_lookups.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               want = due_lookups.pop_front();
               if (rsp_bus.slot !== want.slot) begin
                  $error("slot: expected %0d, actual %0d", want.slot, rsp_bus.slot);
                  error_count++;
               end
               if (rsp_bus.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_bus.hit);
                  error_count++;
               end
               if (rsp_bus.evicted_valid !== want.evicted_valid) begin
                  $error("evicted_valid: expected %0d, actual %0d",
                         want.evicted_valid, rsp_bus.evicted_valid);
                  error_count++;
               end
               if (rsp_bus.evicted_row !== want.evicted_row) begin
                  $error("evicted_row: expected %0d, actual %0d",
                         want.evicted_row, rsp_bus.evicted_row);
                  error_count++;
               end
               if (rsp_bus.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, actual %0d",
                         want.out_of_range, rsp_bus.out_of_range);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 16);
      end
   end

   // watchdog: covers the map clear after reset plus stalls
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule

>>> sim.f
hw/rtl/rcd_pkg.sv
hw/rtl/rcd_if.sv
hw/rtl/rcd_ram.sv
hw/rtl/row_cache_directory_unit.sv
hw/rtl/rcd_checker.sv
dv/tb.sv
